/* design/sbpf_pkg.sv */
// Shared constants, codes and types for the start-byte packet framer.
package sbpf_pkg;

	localparam int PACKET_BYTES = 14;
	localparam int FIFO_PACKETS = 4;

	localparam logic [7:0] START_BYTE_RESET = 8'hFF;

	// Register index decoded from the word address bit
	localparam logic REG_START_BYTE = 1'b0;

	typedef enum logic [1:0] {
		ACT_BYTE  = 2'd0,
		ACT_READ  = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COPY,
		ST_READ,
		ST_EMPTY
	} seq_state_t;

	// Enables for the assembly buffer and the packet store
	typedef struct packed {
		logic asm_we;
		logic asm_re;
		logic st_we;
		logic st_re;
	} ram_ctl_t;

endpackage

/* design/sbpf_if.sv */
// Valid/ready channel interfaces for input items and result items.
interface sbpf_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] data_byte;

	modport source(output valid, action, data_byte, input ready);
	modport sink(input valid, action, data_byte, output ready);
endinterface

interface sbpf_result_if;
	logic        valid;
	logic        ready;
	logic [7:0]  packet_byte;
	logic [3:0]  byte_index;
	logic        last;
	logic        empty_res;
	logic [15:0] drop_count;
	logic [2:0]  stored_packets;

	modport source(output valid, packet_byte, byte_index, last, empty_res, drop_count,
		stored_packets, input ready);
	modport sink(input valid, packet_byte, byte_index, last, empty_res, drop_count,
		stored_packets, output ready);
endinterface

/* design/start_byte_packet_framer_fifo_unit.sv */
// Top level of the start-byte packet framer with packet FIFO.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+---------------------------------------------
//  item     | in  | valid / ready      | action, data_byte
//  result   | out | valid / ready      | packet_byte, byte_index, last, empty_res,
//           |     |                    | drop_count, stored_packets
//  apb      | in  | psel/penable/pready| start_byte at address 0
//
// A completed packet runs a copy loop through the assembly buffer's read port into the
// packet store. A read streams the packet at one byte per cycle while the result side
// does not stall, set by the packet store's single read port.
// Reset is asynchronous and needs no clearing pass; item.ready is low in the loops.
module start_byte_packet_framer_fifo_unit #(
	parameter int PACKET_BYTES = sbpf_pkg::PACKET_BYTES,
	parameter int FIFO_PACKETS = sbpf_pkg::FIFO_PACKETS
) (
	input  logic         clk,
	input  logic         arst_n,
	sbpf_item_if.sink    item,
	sbpf_result_if.source result,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int IW = $clog2(PACKET_BYTES);
	localparam int AW = $clog2(PACKET_BYTES * FIFO_PACKETS);

	logic [7:0]          start_byte_q;
	sbpf_pkg::ram_ctl_t  ram_ctl;
	logic [IW-1:0]       asm_waddr, asm_raddr;
	logic [7:0]          asm_wdata, asm_rdata;
	logic [AW-1:0]       st_waddr, st_raddr;
	logic [7:0]          st_wdata, st_rdata;

	// Configuration register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= sbpf_pkg::START_BYTE_RESET;
		end else if (psel && penable && pwrite && paddr[2] == sbpf_pkg::REG_START_BYTE) begin
			start_byte_q <= pwdata[7:0];
		end
	end

	// Register read-back
	assign pready = 1'b1;
	assign prdata = (paddr[2] == sbpf_pkg::REG_START_BYTE) ? {24'd0, start_byte_q} : 32'd0;

	sbpf_seq #(
		.PACKET_BYTES(PACKET_BYTES),
		.FIFO_PACKETS(FIFO_PACKETS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start_byte (start_byte_q),
		.in_valid   (item.valid),
		.in_ready   (item.ready),
		.in_action  (item.action),
		.in_data    (item.data_byte),
		.out_valid  (result.valid),
		.out_ready  (result.ready),
		.out_byte   (result.packet_byte),
		.out_index  (result.byte_index),
		.out_last   (result.last),
		.out_empty  (result.empty_res),
		.out_drop   (result.drop_count),
		.out_stored (result.stored_packets),
		.ram_ctl    (ram_ctl),
		.asm_waddr  (asm_waddr),
		.asm_wdata  (asm_wdata),
		.asm_raddr  (asm_raddr),
		.asm_rdata  (asm_rdata),
		.st_waddr   (st_waddr),
		.st_wdata   (st_wdata),
		.st_raddr   (st_raddr),
		.st_rdata   (st_rdata)
	);

	// Assembly buffer for the packet being collected
	sbpf_ram #(
		.DEPTH(PACKET_BYTES),
		.WIDTH(8)
	) u_asm_ram (
		.clk   (clk),
		.we    (ram_ctl.asm_we),
		.waddr (asm_waddr),
		.wdata (asm_wdata),
		.re    (ram_ctl.asm_re),
		.raddr (asm_raddr),
		.rdata (asm_rdata)
	);

	// Packet store, one row of PACKET_BYTES per FIFO slot
	sbpf_ram #(
		.DEPTH(PACKET_BYTES * FIFO_PACKETS),
		.WIDTH(8)
	) u_store_ram (
		.clk   (clk),
		.we    (ram_ctl.st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (ram_ctl.st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

endmodule

/* design/sbpf_ram.sv */
// Simple dual-port RAM: one write port, one read port with registered data.
module sbpf_ram #(
	parameter int DEPTH = sbpf_pkg::PACKET_BYTES,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and read; read data holds while re is low
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* design/sbpf_seq.sv */
// Framer sequencer: hunt and collect, packet copy loop, read-out loop, output register.
module sbpf_seq #(
	parameter int PACKET_BYTES = sbpf_pkg::PACKET_BYTES,
	parameter int FIFO_PACKETS = sbpf_pkg::FIFO_PACKETS,
	localparam int IW = $clog2(PACKET_BYTES),
	localparam int AW = $clog2(PACKET_BYTES * FIFO_PACKETS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        start_byte,
	// input transaction
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        in_action,
	input  logic [7:0]        in_data,
	// result transaction
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_byte,
	output logic [3:0]        out_index,
	output logic              out_last,
	output logic              out_empty,
	output logic [15:0]       out_drop,
	output logic [2:0]        out_stored,
	// memories
	output sbpf_pkg::ram_ctl_t ram_ctl,
	output logic [IW-1:0]     asm_waddr,
	output logic [7:0]        asm_wdata,
	output logic [IW-1:0]     asm_raddr,
	input  logic [7:0]        asm_rdata,
	output logic [AW-1:0]     st_waddr,
	output logic [7:0]        st_wdata,
	output logic [AW-1:0]     st_raddr,
	input  logic [7:0]        st_rdata
);

	localparam int SW = $clog2(2 * FIFO_PACKETS);
	localparam int CW = $clog2(PACKET_BYTES + 1);
	localparam logic [SW:0]   SLOT_MOD = (SW + 1)'(2 * FIFO_PACKETS);
	localparam logic [SW:0]   FIFO_N   = (SW + 1)'(FIFO_PACKETS);
	localparam logic [SW-1:0] SLOT_TOP = SW'(2 * FIFO_PACKETS - 1);
	localparam logic [SW-1:0] FIFO_S   = SW'(FIFO_PACKETS);
	localparam logic [CW-1:0] STEP_END = CW'(PACKET_BYTES);
	localparam logic [IW-1:0] IDX_LAST = IW'(PACKET_BYTES - 1);
	localparam logic [AW-1:0] PB_A     = AW'(PACKET_BYTES);

	sbpf_pkg::seq_state_t state_q, state_d;

	logic          collecting_q;
	logic [IW-1:0] bcnt_q;
	logic [SW-1:0] wslot_q, rslot_q;
	logic [15:0]   drop_q;
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] ld_q;
	logic          dv_q;
	logic [AW-1:0] addr_q;
	logic          ov_q;

	logic [SW:0]   diff, fcount;
	logic          full, empty;
	logic [SW-1:0] wslot_inc, rslot_inc;
	logic [SW-1:0] widx, ridx;
	logic [AW-1:0] wbase, rbase;
	logic          in_fire, load_ok;
	logic          byte_take, pkt_done;
	logic          act_read, act_clear;
	logic          issue, load_rd, load_empty;
	logic [IW+3:0] ld_ext;

	// FIFO occupancy from slot counters that run mod twice the depth
	always_comb begin
		diff   = {1'b0, wslot_q} - {1'b0, rslot_q};
		fcount = diff[SW] ? diff + SLOT_MOD : diff;
		full   = fcount >= FIFO_N;
		empty  = fcount == '0;
	end

	// Advance slots and locate packet bases
	always_comb begin
		wslot_inc = (wslot_q == SLOT_TOP) ? '0 : wslot_q + 1'b1;
		rslot_inc = (rslot_q == SLOT_TOP) ? '0 : rslot_q + 1'b1;
		widx      = (wslot_q >= FIFO_S) ? wslot_q - FIFO_S : wslot_q;
		ridx      = (rslot_q >= FIFO_S) ? rslot_q - FIFO_S : rslot_q;
		wbase     = AW'(AW'(widx) * PB_A);
		rbase     = AW'(AW'(ridx) * PB_A);
	end

	// Decode the accepted transaction
	always_comb begin
		in_fire    = in_valid & in_ready;
		load_ok    = ~ov_q | out_ready;
		act_read   = in_fire & (in_action == sbpf_pkg::ACT_READ);
		act_clear  = in_fire & (in_action == sbpf_pkg::ACT_CLEAR);
		byte_take  = in_fire & (in_action == sbpf_pkg::ACT_BYTE)
			& (collecting_q | (in_data == start_byte));
		pkt_done   = byte_take & (bcnt_q == IDX_LAST);
		issue      = (state_q == sbpf_pkg::ST_READ) & (cnt_q != STEP_END) & (~dv_q | load_ok);
		load_rd    = (state_q == sbpf_pkg::ST_READ) & dv_q & load_ok;
		load_empty = (state_q == sbpf_pkg::ST_EMPTY) & load_ok;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sbpf_pkg::ST_IDLE: begin
				if (act_read) begin
					state_d = empty ? sbpf_pkg::ST_EMPTY : sbpf_pkg::ST_READ;
				end else if (pkt_done && !full) begin
					state_d = sbpf_pkg::ST_COPY;
				end
			end
			sbpf_pkg::ST_COPY: begin
				if (cnt_q == STEP_END) begin
					state_d = sbpf_pkg::ST_IDLE;
				end
			end
			sbpf_pkg::ST_READ: begin
				if (load_rd && ld_q == IDX_LAST) begin
					state_d = sbpf_pkg::ST_IDLE;
				end
			end
			sbpf_pkg::ST_EMPTY: begin
				if (load_ok) begin
					state_d = sbpf_pkg::ST_IDLE;
				end
			end
			default: state_d = sbpf_pkg::ST_IDLE;
		endcase
	end

	// Outputs: handshake and memory ports
	always_comb begin
		in_ready       = (state_q == sbpf_pkg::ST_IDLE);
		ram_ctl.asm_we = byte_take;
		ram_ctl.asm_re = (state_q == sbpf_pkg::ST_COPY) & (cnt_q != STEP_END);
		ram_ctl.st_we  = (state_q == sbpf_pkg::ST_COPY) & (cnt_q != '0);
		ram_ctl.st_re  = issue;
		asm_waddr      = bcnt_q;
		asm_wdata      = in_data;
		asm_raddr      = cnt_q[IW-1:0];
		st_waddr       = addr_q;
		st_wdata       = asm_rdata;
		st_raddr       = addr_q;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= sbpf_pkg::ST_IDLE;
			collecting_q <= 1'b0;
			bcnt_q       <= '0;
			wslot_q      <= '0;
			rslot_q      <= '0;
			drop_q       <= '0;
			cnt_q        <= '0;
			ld_q         <= '0;
			dv_q         <= 1'b0;
			ov_q         <= 1'b0;
		end else begin
			state_q <= state_d;
			// Hunt and collect
			if (act_clear) begin
				collecting_q <= 1'b0;
				bcnt_q       <= '0;
				wslot_q      <= '0;
				rslot_q      <= '0;
				drop_q       <= '0;
			end else if (pkt_done) begin
				collecting_q <= 1'b0;
				bcnt_q       <= '0;
				if (full) begin
					drop_q <= drop_q + 16'd1;
				end
			end else if (byte_take) begin
				collecting_q <= 1'b1;
				bcnt_q       <= bcnt_q + 1'b1;
			end
			// Pop the slot when a read starts
			if (act_read && !empty) begin
				rslot_q <= rslot_inc;
			end
			// Copy loop
			if (state_q == sbpf_pkg::ST_COPY) begin
				if (cnt_q == STEP_END) begin
					cnt_q   <= '0;
					wslot_q <= wslot_inc;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			// Read-out loop
			if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (issue) begin
				dv_q <= 1'b1;
			end else if (load_rd) begin
				dv_q <= 1'b0;
			end
			if (load_rd) begin
				if (ld_q == IDX_LAST) begin
					ld_q  <= '0;
					cnt_q <= '0;
				end else begin
					ld_q <= ld_q + 1'b1;
				end
			end
			// Output register valid
			if (load_rd || load_empty) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign ld_ext = (IW + 4)'(ld_q);

	// Shared address register and result payload
	always_ff @(posedge clk) begin
		if (state_q == sbpf_pkg::ST_IDLE) begin
			addr_q <= act_read ? rbase : wbase;
		end else if (ram_ctl.st_we || issue) begin
			addr_q <= addr_q + 1'b1;
		end
		if (load_rd) begin
			out_byte   <= st_rdata;
			out_index  <= ld_ext[3:0];
			out_last   <= (ld_q == IDX_LAST);
			out_empty  <= 1'b0;
			out_drop   <= drop_q;
			out_stored <= fcount[2:0];
		end else if (load_empty) begin
			out_byte   <= '0;
			out_index  <= '0;
			out_last   <= 1'b1;
			out_empty  <= 1'b1;
			out_drop   <= drop_q;
			out_stored <= '0;
		end
	end

	assign out_valid = ov_q;

endmodule

/* design/sbpf_chk.sv */
// Port checker for the framer top level and its bind.
module sbpf_chk #(
	parameter int PACKET_BYTES = sbpf_pkg::PACKET_BYTES
) (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic [1:0]  item_action,
	input logic        result_valid,
	input logic        result_ready,
	input logic [7:0]  result_packet_byte,
	input logic [3:0]  result_byte_index,
	input logic        result_last,
	input logic        result_empty_res,
	input logic [2:0]  result_stored_packets
);

	localparam logic [3:0] IDX_LAST = 4'((PACKET_BYTES - 1) % 16);

	// An empty reply carries fixed fields
	a_empty_reply: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_empty_res |->
			result_last && result_byte_index == 4'd0 && result_packet_byte == 8'd0
			&& result_stored_packets == 3'd0)
		else $error("empty reply with unexpected fields");

	// Last mark on a packet byte only at the final index
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_empty_res |-> (result_last == (result_byte_index == IDX_LAST)))
		else $error("last mark does not match byte index");

	// Block is busy in the cycle after a read transaction
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item_action == sbpf_pkg::ACT_READ |=> !item_ready)
		else $error("item accepted right after a read");

	// Stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(result_packet_byte) && $stable(result_byte_index)
			&& $stable(result_last))
		else $error("stalled result changed");

endmodule

bind start_byte_packet_framer_fifo_unit sbpf_chk #(
	.PACKET_BYTES(PACKET_BYTES)
) u_sbpf_chk (
	.clk                   (clk),
	.arst_n                (arst_n),
	.item_valid            (item.valid),
	.item_ready            (item.ready),
	.item_action           (item.action),
	.result_valid          (result.valid),
	.result_ready          (result.ready),
	.result_packet_byte    (result.packet_byte),
	.result_byte_index     (result.byte_index),
	.result_last           (result.last),
	.result_empty_res      (result.empty_res),
	.result_stored_packets (result.stored_packets)
);

/* bench/start_byte_packet_framer_fifo_unit_tb.sv */
// Testbench for the start-byte packet framer: random traffic checked against a packet predictor.
`timescale 1ns / 1ps

module start_byte_packet_framer_fifo_unit_tb;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam logic [2:0] START_BYTE_ADDR = {sbpf_pkg::REG_START_BYTE, 2'b00};

	// One emitted byte of a popped packet, or an empty reply
	typedef struct packed {
		logic [7:0]  packet_byte;
		logic [3:0]  byte_index;
		logic        last;
		logic        empty_res;
		logic [15:0] drop_count;
		logic [2:0]  stored_packets;
	} packet_beat_t;

	// Tracks framer and packet FIFO state, queues the bytes each read must return
	class framer_scoreboard;
		logic [7:0]   start_byte;
		bit           collecting;
		int unsigned  taken;
		logic [7:0]   assembly[sbpf_pkg::PACKET_BYTES];
		logic [7:0]   store[sbpf_pkg::FIFO_PACKETS][sbpf_pkg::PACKET_BYTES];
		int unsigned  wr_slot;
		int unsigned  rd_slot;
		logic [15:0]  drops;
		packet_beat_t beats_due[$];
		int unsigned  faults;

		function new();
			start_byte = sbpf_pkg::START_BYTE_RESET;
			faults = 0;
			wipe_state();
		endfunction

		function void wipe_state();
			collecting = 1'b0;
			taken = 0;
			wr_slot = 0;
			rd_slot = 0;
			drops = '0;
		endfunction

		// Slot counters wrap at twice the depth so full and empty differ
		function int unsigned held();
			return (wr_slot + 2 * sbpf_pkg::FIFO_PACKETS - rd_slot)
				% (2 * sbpf_pkg::FIFO_PACKETS);
		endfunction

		function void take_byte(logic [7:0] b);
			if (!collecting) begin
				if (b != start_byte)
					return;
				collecting = 1'b1;
				taken = 0;
			end
			assembly[taken] = b;
			taken++;
			if (taken == sbpf_pkg::PACKET_BYTES) begin
				// Push the finished packet, or drop it when the FIFO is full
				if (held() >= sbpf_pkg::FIFO_PACKETS) begin
					drops++;
				end else begin
					for (int i = 0; i < sbpf_pkg::PACKET_BYTES; i++)
						store[wr_slot % sbpf_pkg::FIFO_PACKETS][i] = assembly[i];
					wr_slot = (wr_slot + 1) % (2 * sbpf_pkg::FIFO_PACKETS);
				end
				collecting = 1'b0;
				taken = 0;
			end
		endfunction

		function void pop_packet();
			packet_beat_t beat;
			int unsigned  slot;
			beat.drop_count = drops;
			if (held() == 0) begin
				beat.packet_byte = '0;
				beat.byte_index = '0;
				beat.last = 1'b1;
				beat.empty_res = 1'b1;
				beat.stored_packets = '0;
				beats_due.push_back(beat);
				return;
			end
			slot = rd_slot % sbpf_pkg::FIFO_PACKETS;
			rd_slot = (rd_slot + 1) % (2 * sbpf_pkg::FIFO_PACKETS);
			for (int i = 0; i < sbpf_pkg::PACKET_BYTES; i++) begin
				beat.packet_byte = store[slot][i];
				beat.byte_index = 4'(i);
				beat.last = (i == sbpf_pkg::PACKET_BYTES - 1);
				beat.empty_res = 1'b0;
				beat.stored_packets = 3'(held());
				beats_due.push_back(beat);
			end
		endfunction

		function void note_item(sbpf_pkg::action_t act, logic [7:0] b);
			case (act)
				sbpf_pkg::ACT_BYTE:  take_byte(b);
				sbpf_pkg::ACT_READ:  pop_packet();
				sbpf_pkg::ACT_CLEAR: wipe_state();
				default: ;
			endcase
		endfunction

		function void fault(string msg);
			faults++;
			if (faults <= 10)
				$display("%0t: %s", $time, msg);
		endfunction

		function string show(packet_beat_t b);
			return $sformatf("byte=%02h idx=%0d last=%0b empty=%0b drops=%0d held=%0d",
				b.packet_byte, b.byte_index, b.last, b.empty_res, b.drop_count,
				b.stored_packets);
		endfunction

		function void check_result(packet_beat_t got);
			packet_beat_t want;
			if (beats_due.size() == 0) begin
				fault({"unexpected result: ", show(got)});
				return;
			end
			want = beats_due.pop_front();
			if (got !== want)
				fault({"result mismatch: expected ", show(want), ", got ", show(got)});
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	sbpf_item_if   item_ch();
	sbpf_result_if result_ch();

	framer_scoreboard sb = new();
	int unsigned      items_sent = 0;
	bit               steady_in = 1'b0;

	logic [7:0] corner_bytes[sbpf_pkg::PACKET_BYTES - 1] = '{8'hFF, 8'h00, 8'h80, 8'h7F,
		8'h55, 8'hAA, 8'h01, 8'hFE, 8'h0F, 8'hF0, 8'h33, 8'hCC, 8'hFF};

	start_byte_packet_framer_fifo_unit u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap(bit steady);
		if (steady)
			return 0;
		if ($urandom_range(0, 99) < 88)
			return $urandom_range(0, 3);
		return $urandom_range(8, 30);
	endfunction

	// Random byte that cannot open a packet while hunting
	function automatic logic [7:0] noise_byte();
		logic [7:0] b;
		b = 8'($urandom);
		if (b == sb.start_byte)
			b = b ^ 8'h01;
		return b;
	endfunction

	// Offer one transaction after a random gap; hold valid until it is taken
	task automatic send_item(sbpf_pkg::action_t act, logic [7:0] b);
		int unsigned gap;
		gap = pick_gap(steady_in);
		if (gap != 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.action <= act;
		item_ch.data_byte <= b;
		do @(posedge clk); while (!item_ch.ready);
		sb.note_item(act, b);
		if (act != sbpf_pkg::ACT_NONE)
			items_sent++;
	endtask

	// Hunt noise, start byte, data; sometimes cut short or read mid-assembly
	task automatic send_packet();
		int unsigned hunt;
		int unsigned cut;
		int unsigned peek;
		hunt = $urandom_range(0, 2);
		cut = ($urandom_range(0, 9) == 0) ?
			$urandom_range(1, sbpf_pkg::PACKET_BYTES - 2) : sbpf_pkg::PACKET_BYTES;
		peek = ($urandom_range(0, 6) == 0) ?
			$urandom_range(1, sbpf_pkg::PACKET_BYTES - 2) : sbpf_pkg::PACKET_BYTES;
		repeat (hunt) send_item(sbpf_pkg::ACT_BYTE, noise_byte());
		send_item(sbpf_pkg::ACT_BYTE, sb.start_byte);
		for (int i = 1; i < sbpf_pkg::PACKET_BYTES; i++) begin
			if (i == cut)
				return;
			if (i == peek)
				send_item(sbpf_pkg::ACT_READ, 8'($urandom));
			send_item(sbpf_pkg::ACT_BYTE, 8'($urandom));
		end
	endtask

	task automatic run_phase(int unsigned budget, int unsigned read_pct, int unsigned clear_pct);
		int unsigned stop;
		int unsigned pick;
		stop = items_sent + budget;
		while (items_sent < stop) begin
			steady_in = ($urandom_range(0, 4) == 0);
			pick = $urandom_range(0, 99);
			if (pick < read_pct)
				send_item(sbpf_pkg::ACT_READ, 8'($urandom));
			else if (pick < read_pct + clear_pct)
				send_item(sbpf_pkg::ACT_CLEAR, 8'($urandom));
			else if (pick < read_pct + clear_pct + 5)
				send_item(sbpf_pkg::ACT_NONE, 8'($urandom));
			else if (pick < read_pct + clear_pct + 15)
				send_item(sbpf_pkg::ACT_BYTE, noise_byte());
			else
				send_packet();
		end
	endtask

	// Drop valid, wait for every expected byte, then let a copy loop finish
	task automatic drain();
		item_ch.valid <= 1'b0;
		while (sb.beats_due.size() != 0)
			@(posedge clk);
		repeat (sbpf_pkg::PACKET_BYTES + 6) @(posedge clk);
	endtask

	task automatic apb_write(logic [2:0] addr, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apb_read(logic [2:0] addr, output logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		value = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic verify_start_byte();
		logic [31:0] readback;
		apb_read(START_BYTE_ADDR, readback);
		if (readback[7:0] !== sb.start_byte)
			sb.fault($sformatf("start_byte readback: expected %02h, got %02h",
				sb.start_byte, readback[7:0]));
	endtask

	task automatic set_start_byte(logic [7:0] value);
		apb_write(START_BYTE_ADDR, {24'd0, value});
		sb.start_byte = value;
		verify_start_byte();
	endtask

	// Result side: check each transaction, stall ready at random
	initial begin
		int unsigned  stall;
		bit           steady_out;
		packet_beat_t got;
		stall = 0;
		steady_out = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_ch.valid && result_ch.ready) begin
				got.packet_byte = result_ch.packet_byte;
				got.byte_index = result_ch.byte_index;
				got.last = result_ch.last;
				got.empty_res = result_ch.empty_res;
				got.drop_count = result_ch.drop_count;
				got.stored_packets = result_ch.stored_packets;
				sb.check_result(got);
			end
			if ($urandom_range(0, 49) == 0)
				steady_out = !steady_out;
			if (stall != 0) begin
				stall--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
				if (!steady_out && $urandom_range(0, 3) == 0)
					stall = pick_gap(1'b0);
			end
		end
	end

	// Hard stop for a hung run
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		item_ch.valid <= 1'b0;
		item_ch.action <= sbpf_pkg::ACT_BYTE;
		item_ch.data_byte <= '0;
		result_ch.ready <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		verify_start_byte();

		// Empty read, ignored action, hunt discards, one full packet of corner bytes
		send_item(sbpf_pkg::ACT_READ, 8'h00);
		send_item(sbpf_pkg::ACT_NONE, 8'hFF);
		send_item(sbpf_pkg::ACT_BYTE, 8'h00);
		send_item(sbpf_pkg::ACT_BYTE, 8'hFE);
		send_item(sbpf_pkg::ACT_BYTE, sbpf_pkg::START_BYTE_RESET);
		foreach (corner_bytes[i])
			send_item(sbpf_pkg::ACT_BYTE, corner_bytes[i]);
		// Read during assembly, then clear the partial packet and read empty
		send_item(sbpf_pkg::ACT_BYTE, sbpf_pkg::START_BYTE_RESET);
		send_item(sbpf_pkg::ACT_BYTE, 8'h3C);
		send_item(sbpf_pkg::ACT_READ, 8'hFF);
		send_item(sbpf_pkg::ACT_BYTE, 8'hC3);
		send_item(sbpf_pkg::ACT_CLEAR, 8'h5A);
		send_item(sbpf_pkg::ACT_READ, 8'hA5);
		drain();

		// Fill the FIFO, then drain with reads, then mixed traffic
		set_start_byte(8'h00);
		run_phase(64, 0, 0);
		drain();
		set_start_byte(8'($urandom_range(1, 254)));
		run_phase(12, 40, 3);
		drain();
		set_start_byte(8'hFF);
		run_phase(6, 12, 4);
		drain();

		if (sb.faults == 0 && sb.beats_due.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* sim.f */
design/sbpf_pkg.sv
design/sbpf_if.sv
design/sbpf_ram.sv
design/sbpf_seq.sv
design/start_byte_packet_framer_fifo_unit.sv
design/sbpf_chk.sv
bench/start_byte_packet_framer_fifo_unit_tb.sv
